// File: hdl/i2c_mts_pkg.sv
`default_nettype none

package i2c_mts_pkg;

  typedef enum logic {
    MODE_START = 1'b0,
    MODE_EVENT = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    OUTCOME_BUSY     = 2'd0,
    OUTCOME_OK       = 2'd1,
    OUTCOME_ARB_LOST = 2'd2,
    OUTCOME_NACK     = 2'd3
  } outcome_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] device_address;
    logic [7:0] command_address;
    logic [7:0] byte_count;
    logic       read_request;
    logic       arbitration_lost;
    logic       ack_missing;
    logic [7:0] received_byte;
    logic [7:0] buffer_byte;
  } req_t;

  typedef struct packed {
    logic       write_data_valid;
    logic [7:0] write_data;
    logic       read_data_valid;
    logic [7:0] read_data;
    logic [7:0] buffer_index;
    logic       start_condition;
    logic       master_hold;
    logic       transmit_dir;
    logic       ack_suppress;
    logic       dummy_read;
    outcome_e   outcome;
    logic       engine_enable;
  } rsp_t;

endpackage

`default_nettype wire

// File: hdl/i2c_mts_if.sv
`default_nettype none

interface i2c_mts_req_if import i2c_mts_pkg::*;;
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface i2c_mts_rsp_if import i2c_mts_pkg::*;;
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/i2c_master_transaction_sequencer.sv
// I2C master transfer sequencer.
// req_i takes one beat per item: a start beat (mode 0) opens a transfer with
// device address, command byte, count and direction; an event beat (mode 1)
// reports one finished byte of the bus engine with its status flags.
// rsp_o gives exactly one beat per request beat: the byte to transmit or the
// byte received with its buffer index, and the levels of master mode,
// transmit direction, ACK suppression and engine enable, plus the outcome.
// The response beat is registered: it is valid the cycle after the request
// beat is taken. Throughput: one beat per cycle while rsp_o.ready is high;
// the transfer state registers and the output register are both loaded
// from one level of next-state logic.
// req_i.ready is high while the output register is empty or being drained,
// so a stalled receiver holds the response and blocks only the next beat.
// Reset (rst_ni low, asynchronous) clears the transfer state and empties
// the output register; events then change nothing until a start beat.
`default_nettype none

module i2c_master_transaction_sequencer import i2c_mts_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  i2c_mts_req_if.sink       req_i,
  i2c_mts_rsp_if.source     rsp_o
);

  logic       addr_phase_q, addr_phase_d;
  logic [7:0] bytes_left_q, bytes_left_d;
  logic       read_mode_q, read_mode_d;
  logic [7:0] buf_pos_q, buf_pos_d;
  outcome_e   end_code_q, end_code_d;
  logic [7:0] cmd_byte_q, cmd_byte_d;
  logic       tx_dir_q, tx_dir_d;
  logic       no_ack_q, no_ack_d;
  logic       hold_q, hold_d;
  logic       enable_q, enable_d;

  logic       out_valid_q;
  rsp_t       out_q, out_d;
  logic       in_fire;

  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign in_fire     = req_i.valid && req_i.ready;
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  always_comb begin
    addr_phase_d = addr_phase_q;
    bytes_left_d = bytes_left_q;
    read_mode_d  = read_mode_q;
    buf_pos_d    = buf_pos_q;
    end_code_d   = end_code_q;
    cmd_byte_d   = cmd_byte_q;
    tx_dir_d     = tx_dir_q;
    no_ack_d     = no_ack_q;
    hold_d       = hold_q;
    enable_d     = enable_q;
    out_d        = '0;

    if (req_i.data.mode == MODE_START) begin
      cmd_byte_d       = req_i.data.command_address;
      bytes_left_d     = req_i.data.byte_count;
      read_mode_d      = req_i.data.read_request;
      buf_pos_d        = '0;
      end_code_d       = OUTCOME_BUSY;
      addr_phase_d     = 1'b1;
      enable_d         = 1'b1;
      no_ack_d         = 1'b1;
      tx_dir_d         = 1'b1;
      hold_d           = 1'b1;
      out_d.start_condition  = 1'b1;
      out_d.write_data_valid = 1'b1;
      out_d.write_data       = req_i.data.device_address;
    end else if (enable_q) begin
      if (req_i.data.arbitration_lost) begin
        hold_d     = 1'b0;
        enable_d   = 1'b0;
        end_code_d = OUTCOME_ARB_LOST;
      end else if (tx_dir_q) begin
        if (req_i.data.ack_missing) begin
          hold_d     = 1'b0;
          enable_d   = 1'b0;
          end_code_d = OUTCOME_NACK;
        end else if (addr_phase_q) begin
          out_d.write_data_valid = 1'b1;
          out_d.write_data       = cmd_byte_q;
          addr_phase_d           = 1'b0;
        end else if (!read_mode_q) begin
          if (bytes_left_q != 8'd0) begin
            out_d.write_data_valid = 1'b1;
            out_d.write_data       = req_i.data.buffer_byte;
            out_d.buffer_index     = buf_pos_q;
            buf_pos_d              = buf_pos_q + 8'd1;
            bytes_left_d           = bytes_left_q - 8'd1;
          end else begin
            hold_d     = 1'b0;
            enable_d   = 1'b0;
            end_code_d = OUTCOME_OK;
          end
        end else begin
          // switch to receive, no repeated start
          tx_dir_d = 1'b0;
          no_ack_d = 1'b0;
          if (bytes_left_q == 8'd1) begin
            hold_d = 1'b0;
          end
          out_d.dummy_read = 1'b1;
        end
      end else begin
        if (bytes_left_q == 8'd1) begin
          no_ack_d = 1'b1;
        end else if (bytes_left_q == 8'd0) begin
          hold_d     = 1'b0;
          enable_d   = 1'b0;
          end_code_d = OUTCOME_OK;
        end
        out_d.read_data_valid = 1'b1;
        out_d.read_data       = req_i.data.received_byte;
        out_d.buffer_index    = buf_pos_q;
        buf_pos_d             = buf_pos_q + 8'd1;
        if (bytes_left_q != 8'd0) begin
          bytes_left_d = bytes_left_q - 8'd1;
        end
      end
    end

    out_d.master_hold   = hold_d;
    out_d.transmit_dir  = tx_dir_d;
    out_d.ack_suppress  = no_ack_d;
    out_d.outcome       = end_code_d;
    out_d.engine_enable = enable_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_phase_q <= 1'b0;
      bytes_left_q <= '0;
      read_mode_q  <= 1'b0;
      buf_pos_q    <= '0;
      end_code_q   <= OUTCOME_BUSY;
      cmd_byte_q   <= '0;
      tx_dir_q     <= 1'b0;
      no_ack_q     <= 1'b0;
      hold_q       <= 1'b0;
      enable_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_fire) begin
        addr_phase_q <= addr_phase_d;
        bytes_left_q <= bytes_left_d;
        read_mode_q  <= read_mode_d;
        buf_pos_q    <= buf_pos_d;
        end_code_q   <= end_code_d;
        cmd_byte_q   <= cmd_byte_d;
        tx_dir_q     <= tx_dir_d;
        no_ack_q     <= no_ack_d;
        hold_q       <= hold_d;
        enable_q     <= enable_d;
        out_valid_q  <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= out_d;
    end
  end

  a_fire_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted request produced no response beat");

  a_hold_needs_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !enable_q |-> !hold_q)
    else $error("master mode held with engine disabled");

  a_one_data_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.write_data_valid && out_q.read_data_valid))
    else $error("response both transmits and stores a byte");

  a_start_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.start_condition) |->
      (out_q.write_data_valid && out_q.engine_enable && out_q.outcome == OUTCOME_BUSY))
    else $error("start response inconsistent");

  a_end_disables: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.outcome != OUTCOME_BUSY) |-> !out_q.engine_enable)
    else $error("finished transfer left engine enabled");

endmodule

`default_nettype wire
